// File: hdl/bflf_pkg.sv
// Package for the Bloom-filter link forwarder: sizes, field layouts,
// codes and shared types. No dependencies.
package bflf_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned ID_BITS       = 64;
  localparam int unsigned MAX_LINKS     = 16;

  localparam int unsigned TBL_AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned LINK_LIMIT = (TABLE_ENTRIES < MAX_LINKS) ? TABLE_ENTRIES : MAX_LINKS;

  localparam int unsigned ID_W   = 64;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned PORT_W = 4;
  localparam int unsigned ET_W   = 16;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned CLS_W  = 3;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned CFG_W  = 64;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned IN_DATA_W  = 328;
  localparam int unsigned IN_USER_W  = 5;
  localparam int unsigned OUT_DATA_W = 120;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [ID_W-1:0] ID_MASK = {ID_W{1'b1}} >> (ID_W - ID_BITS);

  localparam logic [CLS_W-1:0] CLS_NOTIFY_LO = 3'd1;
  localparam logic [CLS_W-1:0] CLS_NOTIFY_HI = 3'd3;
  localparam logic [CLS_W-1:0] CLS_RESPONSE  = 3'd5;
  localparam logic [CLS_W-1:0] CLS_LAST      = 3'd5;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_SEND = 2'd1,
    MODE_RECV = 2'd2,
    MODE_NOP  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ACT_FWD   = 2'd0,
    ACT_LOCAL = 2'd1,
    ACT_DROP  = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINKS    = 1'd0,
    CFG_LOCAL_ID = 1'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOCAL_PRE,
    S_SCAN,
    S_LOCAL_POST,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   mask;
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
  } link_entry_t;

  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    mode_e            mode;
    logic [CLS_W-1:0] cls;
    logic [ID_W-1:0]  fid;
    logic [MAC_W-1:0] fsrc;
    logic [MAC_W-1:0] fdst;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [ID_W-1:0]  mask;
    logic [MAC_W-1:0] fsrc;
    logic [MAC_W-1:0] fdst;
    logic [MAC_W-1:0] ent_src;
    logic [MAC_W-1:0] ent_dst;
  } match_op_t;

  typedef struct packed {
    logic contain;
    logic loop;
  } match_res_t;

  typedef struct packed {
    action_e           action;
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  dst_mac;
    logic [MAC_W-1:0]  src_mac;
    logic [ET_W-1:0]   ether_type;
  } result_t;

  function automatic logic [ET_W-1:0] class_ether(input logic [CLS_W-1:0] cls);
    logic [ET_W-1:0] et;
    unique case (cls)
      3'd0:    et = 16'h080a;
      3'd1:    et = 16'h0901;
      3'd2:    et = 16'h0902;
      3'd3:    et = 16'h0903;
      3'd4:    et = 16'h0904;
      3'd5:    et = 16'h0905;
      default: et = '0;
    endcase
    return et;
  endfunction

endpackage

// File: hdl/bflf_link_table.sv
// Link table memory: one write port, one registered read port.
// Depends on bflf_pkg.
module bflf_link_table (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [bflf_pkg::TBL_AW-1:0] wr_addr_i,
  input  bflf_pkg::link_entry_t     wr_entry_i,
  input  bflf_pkg::rd_req_t         rd_req_i,
  output bflf_pkg::link_entry_t     rd_entry_o
);
  import bflf_pkg::*;

  link_entry_t mem [TABLE_ENTRIES];
  link_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req_i.en) begin
      rd_q <= mem[rd_req_i.addr];
    end
  end

  assign rd_entry_o = rd_q;

endmodule

// File: hdl/bflf_match.sv
// Shared compare unit: mask containment and loop-back MAC check.
// Depends on bflf_pkg.
module bflf_match (
  input  bflf_pkg::match_op_t  op_i,
  output bflf_pkg::match_res_t res_o
);
  import bflf_pkg::*;

  logic [ID_W-1:0] mask_m;

  assign mask_m       = op_i.mask & ID_MASK;
  assign res_o.contain = ((op_i.id & mask_m) == mask_m);
  assign res_o.loop    = (op_i.fsrc == op_i.ent_dst) && (op_i.fdst == op_i.ent_src);

endmodule

// File: hdl/bflf_ctrl.sv
// Sequencer: walks the link table one entry per cycle, unless the output stalls,
// through the shared compare unit, holds one pending result and the output register. Depends on bflf_pkg.
module bflf_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  bflf_pkg::item_t            item_i,
  input  logic [bflf_pkg::CNT_W-1:0] count_i,
  input  logic [bflf_pkg::ID_W-1:0]  local_id_i,
  output logic                       ready_o,
  output bflf_pkg::rd_req_t          rd_req_o,
  input  bflf_pkg::link_entry_t      rd_entry_i,
  output bflf_pkg::match_op_t        match_op_o,
  input  bflf_pkg::match_res_t       match_res_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bflf_pkg::result_t          out_res_o,
  output logic                       out_last_o
);
  import bflf_pkg::*;

  state_e            state_q, state_d;
  mode_e             mode_q;
  logic [CLS_W-1:0]  cls_q;
  logic [ID_W-1:0]   fid_q;
  logic [MAC_W-1:0]  fsrc_q, fdst_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              dv_q, dv_d;
  logic              pend_v_q, pend_v_d;
  result_t           pend_q, pend_d;
  logic              out_v_q, out_v_d;
  result_t           out_q, out_d;
  logic              out_last_q, out_last_d;

  logic    is_send, out_free, can_push, want, push, stall, brk, issue, scan_done;
  logic    all_ones;
  result_t new_res, drop_res, local_res;

  assign is_send  = (mode_q == MODE_SEND);
  assign out_free = !out_v_q || out_ready_i;
  assign can_push = !pend_v_q || out_free;
  assign all_ones = &(item_i.fid | ~ID_MASK);

  always_comb begin
    match_op_o.id      = fid_q;
    match_op_o.mask    = (state_q == S_SCAN) ? rd_entry_i.mask : local_id_i;
    match_op_o.fsrc    = fsrc_q;
    match_op_o.fdst    = fdst_q;
    match_op_o.ent_src = rd_entry_i.src_mac;
    match_op_o.ent_dst = rd_entry_i.dst_mac;
  end

  always_comb begin
    drop_res        = '0;
    drop_res.action = ACT_DROP;
    local_res        = '0;
    local_res.action = ACT_LOCAL;
    want    = 1'b0;
    brk     = 1'b0;
    new_res = local_res;
    unique case (state_q)
      S_LOCAL_PRE: begin
        want = match_res_i.contain && (cls_q >= CLS_NOTIFY_LO) && (cls_q <= CLS_NOTIFY_HI);
      end
      S_SCAN: begin
        want = dv_q && match_res_i.contain && (is_send || !match_res_i.loop);
        brk  = want && !is_send && (cls_q == CLS_RESPONSE);
        new_res.action     = ACT_FWD;
        new_res.port       = rd_entry_i.port;
        new_res.dst_mac    = rd_entry_i.dst_mac;
        new_res.src_mac    = rd_entry_i.src_mac;
        new_res.ether_type = is_send ? class_ether(cls_q) : '0;
      end
      S_LOCAL_POST: begin
        want = match_res_i.contain;
      end
      default: begin
        want = 1'b0;
      end
    endcase
    stall     = want && !can_push;
    push      = want && can_push;
    issue     = (state_q == S_SCAN) && !stall && !brk && (rd_idx_q < cnt_q);
    scan_done = !stall && (brk || (rd_idx_q >= cnt_q));
  end

  assign rd_req_o.en   = issue;
  assign rd_req_o.addr = TBL_AW'(rd_idx_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept_i && (item_i.mode == MODE_SEND || item_i.mode == MODE_RECV)) begin
          if (item_i.cls > CLS_LAST) begin
            state_d = S_FLUSH;
          end else if (item_i.mode == MODE_SEND) begin
            state_d = S_LOCAL_PRE;
          end else if (all_ones) begin
            state_d = S_LOCAL_POST;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_LOCAL_PRE: begin
        if (!stall) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_d = is_send ? S_FLUSH : S_LOCAL_POST;
        end
      end
      S_LOCAL_POST: begin
        if (!stall) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // datapath updates
  always_comb begin
    rd_idx_d   = rd_idx_q;
    dv_d       = 1'b0;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    out_v_d    = out_v_q && !out_ready_i;
    out_d      = out_q;
    out_last_d = out_last_q;
    if (accept_i) begin
      rd_idx_d = '0;
    end else if (issue) begin
      rd_idx_d = rd_idx_q + 1'b1;
    end
    if (state_q == S_SCAN) begin
      dv_d = stall ? dv_q : issue;
    end
    if (state_q == S_FLUSH && out_free) begin
      out_v_d    = 1'b1;
      out_d      = pend_v_q ? pend_q : drop_res;
      out_last_d = 1'b1;
      pend_v_d   = 1'b0;
    end else if (push) begin
      if (pend_v_q) begin
        out_v_d    = 1'b1;
        out_d      = pend_q;
        out_last_d = 1'b0;
      end
      pend_v_d = 1'b1;
      pend_d   = new_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_idx_q <= '0;
      dv_q     <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      dv_q     <= dv_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
    if (accept_i) begin
      mode_q <= item_i.mode;
      cls_q  <= item_i.cls;
      fid_q  <= item_i.fid & ID_MASK;
      fsrc_q <= item_i.fsrc;
      fdst_q <= item_i.fdst;
      cnt_q  <= count_i;
    end
  end

  assign ready_o     = (state_q == S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule

// File: hdl/bloom_filter_link_forwarder.sv
// Bloom-filter link forwarder, top level: stream ports, configuration
// registers, link table, compare unit and sequencer. Depends on bflf_pkg.
//
// Usage: items enter on the s_axis channel; tuser selects load, send or
// receive. A load item writes one link table entry and gives no result; the
// block is ready again in the next cycle. A send or receive item holds
// s_axis_tready low while the sequencer checks the local link identifier
// (before the table for send, after it for receive) and reads the table
// one entry per cycle unless the output stalls (one memory read port, one
// shared compare unit). Each matching entry gives a forward result (on receive not a
// loop-back one, and for a response only the first); a deliver result may join them,
// a drop result only when the item found nothing else; the final one carries m_axis_tlast.
// Results leave through an output register behind one pending stage; a
// result waits there until the next one is found or the item ends, and the
// final result turns valid in the cycle in which s_axis_tready returns high.
// When m_axis_tready is low the sequencer holds its table read and waits;
// nothing is lost. Reset clears the sequencer, the configuration registers
// and the output valid; the table contents are kept undefined until loaded.
// Configuration writes take effect at once and belong only between items.
module bloom_filter_link_forwarder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // forward_id, frame_src_mac, frame_dst_mac, entry_index, entry_link_id,
  // entry_port, entry_src_mac, entry_dst_mac
  input  logic [bflf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // mode, packet_class
  input  logic [bflf_pkg::IN_USER_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // link_port, out_dst_mac, out_src_mac, ether_type, zero pad
  output logic [bflf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // action
  output logic [bflf_pkg::OUT_USER_W-1:0]     m_axis_tuser,
  output logic                                m_axis_tlast,
  input  logic                                cfg_we_i,
  input  logic [bflf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bflf_pkg::CFG_W-1:0]          cfg_data_i
);
  import bflf_pkg::*;

  logic [CNT_W-1:0] links_q;
  logic [ID_W-1:0]  local_id_q;
  logic [CNT_W-1:0] count;

  logic             accept, ready;
  item_t            item;
  logic [IDX_W-1:0] entry_index;
  link_entry_t      wr_entry;
  logic             wr_en;
  rd_req_t          rd_req;
  link_entry_t      rd_entry;
  match_op_t        match_op;
  match_res_t       match_res;
  result_t          out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      links_q    <= '0;
      local_id_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LINKS:    links_q    <= cfg_data_i[CNT_W-1:0];
        CFG_LOCAL_ID: local_id_q <= cfg_data_i[ID_W-1:0];
        default:      links_q    <= links_q;
      endcase
    end
  end

  assign count = (links_q > CNT_W'(LINK_LIMIT)) ? CNT_W'(LINK_LIMIT) : links_q;

  assign item.mode = mode_e'(s_axis_tuser[1:0]);
  assign item.cls  = s_axis_tuser[4:2];
  assign item.fid  = s_axis_tdata[63:0];
  assign item.fsrc = s_axis_tdata[111:64];
  assign item.fdst = s_axis_tdata[159:112];

  assign entry_index      = s_axis_tdata[163:160];
  assign wr_entry.mask    = s_axis_tdata[227:164];
  assign wr_entry.port    = s_axis_tdata[231:228];
  assign wr_entry.src_mac = s_axis_tdata[279:232];
  assign wr_entry.dst_mac = s_axis_tdata[327:280];

  assign accept = s_axis_tvalid && ready;
  assign wr_en  = accept && (item.mode == MODE_LOAD) &&
                  (int'(entry_index) < int'(TABLE_ENTRIES));

  bflf_link_table u_table (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (TBL_AW'(entry_index)),
    .wr_entry_i (wr_entry),
    .rd_req_i   (rd_req),
    .rd_entry_o (rd_entry)
  );

  bflf_match u_match (
    .op_i  (match_op),
    .res_o (match_res)
  );

  bflf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item),
    .count_i     (count),
    .local_id_i  (local_id_q),
    .ready_o     (ready),
    .rd_req_o    (rd_req),
    .rd_entry_i  (rd_entry),
    .match_op_o  (match_op),
    .match_res_i (match_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res),
    .out_last_o  (m_axis_tlast)
  );

  assign s_axis_tready = ready;
  assign m_axis_tuser  = out_res.action;
  assign m_axis_tdata  = {4'b0000, out_res.ether_type, out_res.src_mac,
                          out_res.dst_mac, out_res.port};

endmodule

// File: hdl/bflf_checker.sv
// Port-level checker for the Bloom-filter link forwarder, bound to the top
// level. Depends on bflf_pkg.
module bflf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [bflf_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bflf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [bflf_pkg::OUT_USER_W-1:0] m_axis_tuser,
  input logic                            m_axis_tlast
);
  import bflf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  a_drop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ACT_DROP) |-> m_axis_tlast)
    else $error("drop item not marked last");

  a_nonfwd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ACT_FWD) |-> (m_axis_tdata == '0))
    else $error("deliver or drop item carries link data");

  a_busy_after_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready &&
      (s_axis_tuser[1:0] == MODE_SEND || s_axis_tuser[1:0] == MODE_RECV)
      |=> !s_axis_tready)
    else $error("input ready during lookup");

endmodule

bind bloom_filter_link_forwarder bflf_checker u_bflf_checker (.*);
